// ----- rtl/acl_rm_pkg.sv -----
// acl_rm_pkg: types and constants shared by the acl rule match unit
// used by every file of the block; no dependencies
package acl_rm_pkg;

  localparam int unsigned KEY_W = 32;

  localparam logic [3:0] MAX_FIELDS = 4'd8;

  // field type codes
  localparam logic [1:0] TYPE_PREFIX = 2'd0;
  localparam logic [1:0] TYPE_RANGE  = 2'd1;
  localparam logic [1:0] TYPE_EXACT  = 2'd2;

  // field width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FIELD_COUNT = 2'd0;
  localparam logic [1:0] CFG_TYPE_MAP    = 2'd1;
  localparam logic [1:0] CFG_WIDTH_MAP   = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // classified field, front to back
  typedef struct packed {
    logic             field_match;
    logic             interval_ok;
    logic [KEY_W-1:0] interval_low;
    logic [KEY_W-1:0] interval_high;
    logic             last_field;
  } cls_item_t;

endpackage

// ----- rtl/acl_rm_if.sv -----
// acl_rm_in_if and acl_rm_out_if: valid/ready channels of the rule match unit
// depends on acl_rm_pkg
interface acl_rm_in_if
  import acl_rm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       field_index;
  logic [KEY_W-1:0] key_value;
  logic [KEY_W-1:0] rule_value;
  logic [KEY_W-1:0] rule_mask_range;
  logic             last_field;

  modport source (output valid, field_index, key_value, rule_value, rule_mask_range,
                  last_field, input ready);
  modport sink (input valid, field_index, key_value, rule_value, rule_mask_range,
                last_field, output ready);
endinterface

interface acl_rm_out_if
  import acl_rm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             field_match;
  logic             rule_match;
  logic             interval_ok;
  logic [KEY_W-1:0] interval_low;
  logic [KEY_W-1:0] interval_high;
  logic             last_result;

  modport source (output valid, field_match, rule_match, interval_ok, interval_low,
                  interval_high, last_result, input ready);
  modport sink (input valid, field_match, rule_match, interval_ok, interval_low,
                interval_high, last_result, output ready);
endinterface

// ----- rtl/acl_multi_field_rule_match_unit.sv -----
// acl_multi_field_rule_match_unit: top level of the acl rule match unit
// depends on acl_rm_pkg, acl_rm_if, acl_rm_front, acl_rm_queue, acl_rm_back
//
//   channel  direction  handshake          carries
//   in_ch    sink       valid/ready        one key field and its rule field
//   out_ch   source     valid/ready        field verdict, rule verdict, interval
//   cfg_*    sink       write enable only  field count, type map, width map
//
// one item per cycle unless out_ch stalls; items pass the queue, then the output register
// the field compare sits between the input and the queue, the verdict in the output register
// the queue lets input keep flowing for QUEUE_DEPTH items while the output stalls
// synchronous active-low reset clears config, queue, output valid and the running verdict
module acl_multi_field_rule_match_unit
  import acl_rm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  acl_rm_in_if.sink             in_ch,
  acl_rm_out_if.source          out_ch
);

  cls_item_t cls_item;
  cls_item_t q_item;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      push;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  acl_rm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .field_index     (in_ch.field_index),
    .key_value       (in_ch.key_value),
    .rule_value      (in_ch.rule_value),
    .rule_mask_range (in_ch.rule_mask_range),
    .last_field      (in_ch.last_field),
    .cls_item        (cls_item)
  );

  acl_rm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  acl_rm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .field_match   (out_ch.field_match),
    .rule_match    (out_ch.rule_match),
    .interval_ok   (out_ch.interval_ok),
    .interval_low  (out_ch.interval_low),
    .interval_high (out_ch.interval_high),
    .last_result   (out_ch.last_result)
  );

endmodule

// ----- rtl/acl_rm_front.sv -----
// acl_rm_front: configuration registers and per-field classification
// depends on acl_rm_pkg
module acl_rm_front
  import acl_rm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [2:0]            field_index,
  input  logic [KEY_W-1:0]      key_value,
  input  logic [KEY_W-1:0]      rule_value,
  input  logic [KEY_W-1:0]      rule_mask_range,
  input  logic                  last_field,
  output cls_item_t             cls_item
);

  logic [3:0]  field_count_r;
  logic [15:0] field_type_map_r;
  logic [15:0] field_width_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_count_r     <= '0;
      field_type_map_r  <= '0;
      field_width_map_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIELD_COUNT: field_count_r     <= cfg_wdata[3:0];
        CFG_TYPE_MAP:    field_type_map_r  <= cfg_wdata;
        CFG_WIDTH_MAP:   field_width_map_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [3:0]       count;
  logic             in_use;
  logic [1:0]       ftype;
  logic [1:0]       wcode;
  logic [5:0]       bits;
  logic [KEY_W-1:0] wm;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] val;
  logic [KEY_W-1:0] mr;
  logic             empty;
  logic [5:0]       len;
  logic [5:0]       sh;
  logic [KEY_W-1:0] host;
  logic             hit;
  logic             iok;
  logic [KEY_W-1:0] ilow;
  logic [KEY_W-1:0] ihigh;

  assign count  = (field_count_r > MAX_FIELDS) ? MAX_FIELDS : field_count_r;
  assign in_use = {1'b0, field_index} < count;
  assign ftype  = field_type_map_r[{field_index, 1'b0} +: 2];
  assign wcode  = field_width_map_r[{field_index, 1'b0} +: 2];

  always_comb begin
    unique case (wcode)
      WIDTH_8: begin
        bits = 6'd8;
        wm   = 32'h0000_00FF;
      end
      WIDTH_16: begin
        bits = 6'd16;
        wm   = 32'h0000_FFFF;
      end
      default: begin
        bits = 6'd32;
        wm   = 32'hFFFF_FFFF;
      end
    endcase
  end

  assign key   = key_value & wm;
  assign val   = rule_value & wm;
  assign mr    = rule_mask_range & wm;
  assign empty = (val == '0) && (mr == '0);

  // prefix length clamped to the field width
  assign len  = (mr > {26'd0, bits}) ? bits : mr[5:0];
  assign sh   = bits - len;
  assign host = (len == 6'd0) ? wm : ((32'd1 << sh[4:0]) - 32'd1);

  always_comb begin
    hit   = 1'b0;
    iok   = 1'b0;
    ilow  = '0;
    ihigh = '0;
    unique case (ftype)
      TYPE_PREFIX: begin
        hit   = (len == 6'd0) || (((val ^ key) & ~host) == '0);
        iok   = 1'b1;
        ilow  = val & ~host & wm;
        ihigh = (val | host) & wm;
      end
      TYPE_RANGE: begin
        hit   = (key >= val) && (key <= mr);
        iok   = 1'b1;
        ilow  = val;
        ihigh = mr;
      end
      TYPE_EXACT: begin
        hit = ((val ^ key) & mr) == '0;
        if (mr == wm) begin
          iok   = 1'b1;
          ilow  = val;
          ihigh = val;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cls_item.last_field = last_field;
    if (in_use) begin
      cls_item.field_match   = empty | hit;
      cls_item.interval_ok   = iok;
      cls_item.interval_low  = ilow;
      cls_item.interval_high = ihigh;
    end else begin
      cls_item.field_match   = 1'b1;
      cls_item.interval_ok   = 1'b0;
      cls_item.interval_low  = '0;
      cls_item.interval_high = '0;
    end
  end

endmodule

// ----- rtl/acl_rm_queue.sv -----
// acl_rm_queue: short fifo of classified items between front and back
// depends on acl_rm_pkg
module acl_rm_queue
  import acl_rm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/acl_rm_back.sv -----
// acl_rm_back: running rule verdict and output register
// depends on acl_rm_pkg
module acl_rm_back
  import acl_rm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  cls_item_t        q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             field_match,
  output logic             rule_match,
  output logic             interval_ok,
  output logic [KEY_W-1:0] interval_low,
  output logic [KEY_W-1:0] interval_high,
  output logic             last_result
);

  logic      out_valid_r, out_valid_nxt;
  logic      match_so_far_r, match_so_far_nxt;
  logic      rule_r;
  cls_item_t item_r;
  logic      rule_now;

  assign q_pop    = q_not_empty && (!out_valid_r || out_ready);
  assign rule_now = match_so_far_r & q_item.field_match;

  always_comb begin
    out_valid_nxt    = out_valid_r;
    match_so_far_nxt = match_so_far_r;
    if (q_pop) begin
      out_valid_nxt    = 1'b1;
      match_so_far_nxt = q_item.last_field ? 1'b1 : rule_now;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      match_so_far_r <= 1'b1;
    end else begin
      out_valid_r    <= out_valid_nxt;
      match_so_far_r <= match_so_far_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      rule_r <= rule_now;
    end
  end

  assign out_valid     = out_valid_r;
  assign field_match   = item_r.field_match;
  assign rule_match    = rule_r;
  assign interval_ok   = item_r.interval_ok;
  assign interval_low  = item_r.interval_low;
  assign interval_high = item_r.interval_high;
  assign last_result   = item_r.last_field;

endmodule

// ----- dv/acl_multi_field_rule_match_unit_test.sv -----
// acl_multi_field_rule_match_unit_test: self-checking testbench of the acl rule match unit
// bursty field items against a stalling receiver, each result predicted and compared in order
// depends on acl_rm_pkg, acl_rm_if and acl_multi_field_rule_match_unit
module acl_multi_field_rule_match_unit_test;
  import acl_rm_pkg::*;

  localparam logic [1:0] TYPE_UNUSED = 2'd3;
  localparam logic [1:0] WIDTH_SPARE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 108;

  localparam logic [15:0] DIRECTED_TYPES = {TYPE_PREFIX, TYPE_EXACT, TYPE_RANGE, TYPE_PREFIX,
                                            TYPE_UNUSED, TYPE_EXACT, TYPE_RANGE, TYPE_PREFIX};
  localparam logic [15:0] DIRECTED_WIDTHS = {WIDTH_32, WIDTH_16, WIDTH_8, WIDTH_SPARE,
                                             WIDTH_32, WIDTH_32, WIDTH_16, WIDTH_8};

  typedef struct packed {
    logic [2:0]       field_index;
    logic [KEY_W-1:0] key_value;
    logic [KEY_W-1:0] rule_value;
    logic [KEY_W-1:0] rule_mask_range;
    logic             last_field;
  } field_item_t;

  typedef struct packed {
    logic             field_match;
    logic             rule_match;
    logic             interval_ok;
    logic [KEY_W-1:0] interval_low;
    logic [KEY_W-1:0] interval_high;
    logic             last_result;
  } field_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  acl_rm_in_if  in_ch ();
  acl_rm_out_if out_ch ();

  acl_multi_field_rule_match_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [3:0]    field_count_reg;
  logic [15:0]   type_map_reg;
  logic [15:0]   width_map_reg;
  logic          verdict_so_far;
  field_result_t pending_results[$];
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   verdicts_closed;
  int unsigned   settings_used;
  int unsigned   mismatch_count;
  int unsigned   idle_cycles;
  int unsigned   burst_left;

  function automatic int unsigned field_bits(logic [1:0] code);
    case (code)
      WIDTH_8:  return 8;
      WIDTH_16: return 16;
      default:  return 32;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] width_ones(int unsigned bits);
    return (bits >= 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
  endfunction

  // expected result of one field; also advances the running rule verdict
  function automatic field_result_t classify_field(field_item_t it);
    field_result_t    r;
    logic [3:0]       in_use;
    logic [1:0]       ftype;
    int unsigned      bits;
    int unsigned      len;
    int unsigned      sh;
    logic [KEY_W-1:0] wm;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] val;
    logic [KEY_W-1:0] mr;
    logic [KEY_W-1:0] host;
    logic             hit;
    r = '0;
    r.field_match = 1'b1;
    r.last_result = it.last_field;
    in_use = (field_count_reg > MAX_FIELDS) ? MAX_FIELDS : field_count_reg;
    if ({1'b0, it.field_index} < in_use) begin
      ftype = type_map_reg[2*it.field_index +: 2];
      bits = field_bits(width_map_reg[2*it.field_index +: 2]);
      wm = width_ones(bits);
      key = it.key_value & wm;
      val = it.rule_value & wm;
      mr = it.rule_mask_range & wm;
      hit = 1'b0;
      case (ftype)
        TYPE_PREFIX: begin
          len = (mr > bits) ? bits : mr;
          if (len == 0) begin
            hit = 1'b1;
            host = wm;
          end else begin
            sh = bits - len;
            hit = (val >> sh) == (key >> sh);
            host = (32'd1 << sh) - 32'd1;
          end
          r.interval_ok = 1'b1;
          r.interval_low = val & ~host & wm;
          r.interval_high = (val | host) & wm;
        end
        TYPE_RANGE: begin
          hit = (key >= val) && (key <= mr);
          r.interval_ok = 1'b1;
          r.interval_low = val;
          r.interval_high = mr;
        end
        TYPE_EXACT: begin
          hit = (val & mr) == (key & mr);
          if (mr == wm) begin
            r.interval_ok = 1'b1;
            r.interval_low = val;
            r.interval_high = val;
          end
        end
        default: hit = 1'b0;
      endcase
      r.field_match = (val == '0 && mr == '0) ? 1'b1 : hit;
    end
    verdict_so_far = verdict_so_far & r.field_match;
    r.rule_match = verdict_so_far;
    if (it.last_field) verdict_so_far = 1'b1;
    return r;
  endfunction

  function automatic field_item_t make_item(logic [2:0] idx, logic [KEY_W-1:0] key,
                                            logic [KEY_W-1:0] val, logic [KEY_W-1:0] mr,
                                            logic last);
    field_item_t it;
    it.field_index = idx;
    it.key_value = key;
    it.rule_value = val;
    it.rule_mask_range = mr;
    it.last_field = last;
    return it;
  endfunction

  // random field shaped by the current configuration, mostly built to match
  function automatic field_item_t random_field(logic [2:0] idx, logic last);
    field_item_t      it;
    logic [1:0]       ftype;
    int unsigned      bits;
    int unsigned      len;
    logic [KEY_W-1:0] wm;
    logic [KEY_W-1:0] kk;
    logic [KEY_W-1:0] host;
    logic [KEY_W-1:0] mask;
    logic             want_hit;
    ftype = type_map_reg[2*idx +: 2];
    bits = field_bits(width_map_reg[2*idx +: 2]);
    wm = width_ones(bits);
    want_hit = ($urandom_range(0, 9) < 7);
    kk = $urandom & wm;
    it = make_item(idx, kk, $urandom & wm, $urandom & wm, last);
    case (ftype)
      TYPE_PREFIX: begin
        if ($urandom_range(0, 9) != 0) it.rule_mask_range = $urandom_range(0, bits + 1);
        len = (it.rule_mask_range > bits) ? bits : it.rule_mask_range;
        host = (len == 0) ? wm : (32'd1 << (bits - len)) - 32'd1;
        if (want_hit) it.rule_value = (kk & ~host) | (it.rule_value & host);
      end
      TYPE_RANGE: begin
        if (want_hit) begin
          it.rule_value = $urandom_range(0, kk);
          it.rule_mask_range = $urandom_range(kk, wm);
        end
      end
      TYPE_EXACT: begin
        case ($urandom_range(0, 2))
          0:       mask = wm;
          1:       mask = $urandom & wm;
          default: mask = $urandom & $urandom & wm;
        endcase
        it.rule_mask_range = mask;
        if (want_hit) it.rule_value = (kk & mask) | (it.rule_value & ~mask);
      end
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0) begin
      it.rule_value = '0;
      it.rule_mask_range = '0;
    end
    // bits above the field width must be ignored
    if ($urandom_range(0, 3) == 0) begin
      it.key_value |= $urandom & ~wm;
      it.rule_value |= $urandom & ~wm;
      it.rule_mask_range |= $urandom & ~wm;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(field_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.field_index <= it.field_index;
    in_ch.key_value <= it.key_value;
    in_ch.rule_value <= it.rule_value;
    in_ch.rule_mask_range <= it.rule_mask_range;
    in_ch.last_field <= it.last_field;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_config(logic [3:0] count, logic [15:0] types, logic [15:0] widths);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIELD_COUNT;
    cfg_wdata <= {12'($urandom), count};
    @(posedge clk);
    cfg_index <= CFG_TYPE_MAP;
    cfg_wdata <= types;
    @(posedge clk);
    cfg_index <= CFG_WIDTH_MAP;
    cfg_wdata <= widths;
    @(posedge clk);
    cfg_we <= 1'b0;
    field_count_reg = count;
    type_map_reg = types;
    width_map_reg = widths;
    settings_used++;
  endtask

  task automatic test_unused_fields();
    send_item(make_item(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(3'd7, 32'h0, 32'h0, 32'h0, 1'b1));
    send_item(make_item(3'd3, $urandom, $urandom, $urandom, 1'b1));
    send_item(make_item(3'd5, $urandom, $urandom, $urandom, 1'b0));
    wait_for_results();
  endtask

  task automatic test_directed_cases();
    apply_config(4'd8, DIRECTED_TYPES, DIRECTED_WIDTHS);
    // one-byte prefix: zero length, clamped length, miss, empty
    send_item(make_item(3'd0, 32'h0000_0037, 32'h0000_005A, 32'd0, 1'b0));
    send_item(make_item(3'd0, 32'hFFFF_FFA5, 32'hFFFF_FFA5, 32'd12, 1'b0));
    send_item(make_item(3'd0, 32'h0000_000F, 32'h0000_00F0, 32'd4, 1'b0));
    send_item(make_item(3'd0, 32'h0000_0000, 32'h0, 32'h0, 1'b1));
    // two-byte range: top edge, inverted bounds, empty
    send_item(make_item(3'd1, 32'h0000_FFFF, 32'h0000_0010, 32'h0000_FFFF, 1'b0));
    send_item(make_item(3'd1, 32'h0000_4000, 32'h0000_8000, 32'h0000_0100, 1'b0));
    send_item(make_item(3'd1, 32'h0000_0005, 32'h0, 32'h0, 1'b1));
    // four-byte exact: full mask, partial mask, empty
    send_item(make_item(3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(3'd2, 32'h00AB_12CD, 32'h0000_1200, 32'h0000_FF00, 1'b0));
    send_item(make_item(3'd2, 32'h1234_5678, 32'h0, 32'h0, 1'b0));
    send_item(make_item(3'd3, 32'h1, 32'h1, 32'h1, 1'b1));
    // spare width code acts as four bytes
    send_item(make_item(3'd4, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'd32, 1'b0));
    send_item(make_item(3'd4, 32'h0, 32'h8000_0000, 32'd1, 1'b0));
    send_item(make_item(3'd5, 32'h0000_00FF, 32'h0, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(3'd6, 32'h0001_1234, 32'hFFFF_1234, 32'h0000_FFFF, 1'b0));
    send_item(make_item(3'd7, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 1'b1));
    wait_for_results();
    // field count above the maximum
    apply_config(4'd15, DIRECTED_TYPES, DIRECTED_WIDTHS);
    send_item(make_item(3'd7, 32'h0, 32'h0000_0001, 32'd40, 1'b0));
    send_item(make_item(3'd6, 32'h0000_ABCD, 32'h0000_ABCD, 32'h0000_FFFF, 1'b1));
    wait_for_results();
    apply_config(4'd3, DIRECTED_TYPES, DIRECTED_WIDTHS);
    send_item(make_item(3'd3, 32'h5, 32'h5, 32'h5, 1'b0));
    send_item(make_item(3'd7, 32'hFFFF_FFFF, 32'h1, 32'h1, 1'b1));
    wait_for_results();
  endtask

  task automatic test_random_rules();
    int unsigned sent;
    int unsigned run_len;
    logic        noisy;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_config(4'd8, 16'($urandom), 16'($urandom));
        1: apply_config(4'd15, {8{TYPE_PREFIX}}, {8{WIDTH_SPARE}});
        2: apply_config(4'd8, {8{TYPE_EXACT}}, {8{WIDTH_8}});
        3: apply_config(4'd3, 16'($urandom), 16'($urandom));
        4: apply_config(4'd8, {8{TYPE_RANGE}}, {8{WIDTH_16}});
        default: apply_config(4'($urandom_range(1, 8)), 16'($urandom), 16'($urandom));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run_len = $urandom_range(1, 8);
        noisy = ($urandom_range(0, 7) == 0);
        for (int pos = 0; pos < run_len; pos++) begin
          if (noisy) send_item(random_field(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
          else send_item(random_field(3'(pos), pos == run_len - 1));
          sent++;
        end
      end
      wait_for_results();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [15:0] ready_pattern;
    int unsigned slot;
    ready_pattern = '1;
    slot = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (slot == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = 16'($urandom);
          2:       ready_pattern = 16'($urandom & $urandom);
          default: ready_pattern = 16'hFFFF << $urandom_range(1, 15);
        endcase
      end
      out_ch.ready <= ready_pattern[slot];
      slot = (slot + 1) % 16;
    end
  end

  always @(posedge clk) begin
    field_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(classify_field(make_item(in_ch.field_index,
          in_ch.key_value, in_ch.rule_value, in_ch.rule_mask_range, in_ch.last_field)));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("item with nothing pending", '0, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.field_match !== want.field_match)
            report_mismatch("field_match", KEY_W'(out_ch.field_match),
                            KEY_W'(want.field_match));
          if (out_ch.rule_match !== want.rule_match)
            report_mismatch("rule_match", KEY_W'(out_ch.rule_match),
                            KEY_W'(want.rule_match));
          if (out_ch.interval_ok !== want.interval_ok)
            report_mismatch("interval_ok", KEY_W'(out_ch.interval_ok),
                            KEY_W'(want.interval_ok));
          if (out_ch.interval_low !== want.interval_low)
            report_mismatch("interval_low", out_ch.interval_low, want.interval_low);
          if (out_ch.interval_high !== want.interval_high)
            report_mismatch("interval_high", out_ch.interval_high, want.interval_high);
          if (out_ch.last_result !== want.last_result)
            report_mismatch("last_result", KEY_W'(out_ch.last_result),
                            KEY_W'(want.last_result));
          if (want.last_result) verdicts_closed++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FIELD_COUNT;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.field_index <= '0;
    in_ch.key_value <= '0;
    in_ch.rule_value <= '0;
    in_ch.rule_mask_range <= '0;
    in_ch.last_field <= 1'b0;
    field_count_reg = '0;
    type_map_reg = '0;
    width_map_reg = '0;
    verdict_so_far = 1'b1;
    items_sent = 0;
    results_seen = 0;
    verdicts_closed = 0;
    settings_used = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_unused_fields();
    test_directed_cases();
    test_random_rules();
    repeat (8) @(posedge clk);
    $display("covered %0d field items and %0d results, %0d rule verdicts closed",
             items_sent, results_seen, verdicts_closed);
    $display("over %0d register settings, prefix, range, exact and unused field types",
             settings_used);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/acl_rm_pkg.sv
rtl/acl_rm_if.sv
rtl/acl_rm_front.sv
rtl/acl_rm_queue.sv
rtl/acl_rm_back.sv
rtl/acl_multi_field_rule_match_unit.sv
dv/acl_multi_field_rule_match_unit_test.sv
